/* hdl/vkd_pkg.sv */
// Shared constants and helpers for the K=3 rate one-half hard-decision Viterbi decoder.
// No dependencies; imported by vkd_acs and viterbi_k3_hard_decision_decoder.
package vkd_pkg;

   localparam int METRIC_WIDTH_DEFAULT = 10;   // path metric width
   localparam int CFG_WIDTH            = 10;   // initial_other_metric register width
   localparam int CFG_RESET            = 3;    // initial_other_metric after reset
   localparam int NUM_STATES           = 4;
   localparam int REQ_DATA_WIDTH       = 8;
   localparam int RSP_DATA_WIDTH       = 8;

   // Hamming distance between the received pair and a branch symbol
   function automatic logic [1:0] branch_distance(input logic [1:0] rx, input logic [1:0] sym);
      logic [1:0] diff;
      diff = rx ^ sym;
      return {1'b0, diff[1]} + {1'b0, diff[0]};
   endfunction

endpackage

/* hdl/vkd_acs.sv */
// One add-compare-select unit with saturating result.
// Depends on vkd_pkg for the default metric width.
module vkd_acs #(
   parameter int METRIC_WIDTH = vkd_pkg::METRIC_WIDTH_DEFAULT
) (
   input  logic [METRIC_WIDTH-1:0] metric_a,
   input  logic [1:0]              branch_a,
   input  logic [METRIC_WIDTH-1:0] metric_b,
   input  logic [1:0]              branch_b,
   output logic [METRIC_WIDTH-1:0] metric_out
);
   import vkd_pkg::*;

   logic [METRIC_WIDTH:0] sum_a;
   logic [METRIC_WIDTH:0] sum_b;
   logic [METRIC_WIDTH:0] chosen;

   assign sum_a = {1'b0, metric_a} + (METRIC_WIDTH+1)'(branch_a);
   assign sum_b = {1'b0, metric_b} + (METRIC_WIDTH+1)'(branch_b);

   // first candidate wins a tie
   assign chosen = (sum_a <= sum_b) ? sum_a : sum_b;

   // clip at the top of the metric range
   assign metric_out = chosen[METRIC_WIDTH] ? {METRIC_WIDTH{1'b1}} : chosen[METRIC_WIDTH-1:0];

endmodule

/* hdl/viterbi_k3_hard_decision_decoder.sv */
// Top level of the K=3 (generators 7, 5) rate one-half hard-decision Viterbi decoder.
// Depends on vkd_pkg and vkd_acs.
//
// Takes one received code-bit pair per request and returns one decision per request, one
// request per clock sustained while results are taken. The four add-compare-select units
// and the tracked-state step sit between the path metric registers and the output register,
// so a result appears in the cycle after its request is accepted and a new request is taken
// while the previous result waits, as long as the output register is empty or being drained.
// There is no traceback: the decision is the upper bit of a tracked state that follows the
// better successor. A request with the start flag reloads metrics {0, m, m, m}
// (m = initial_other_metric, clipped to the metric width) and state zero before the pair is
// used; a register write only affects the next start.
module viterbi_k3_hard_decision_decoder #(
   parameter int METRIC_WIDTH = vkd_pkg::METRIC_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vkd_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,   // [0] code_bit_first, [1] code_bit_second
   input  logic                                req_tuser,   // [0] stream_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vkd_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,   // [0] decoded_bit, [2:1] tracked_state_out
   input  logic                                csr_wr_en,
   input  logic [vkd_pkg::CFG_WIDTH-1:0]       csr_wr_data
);
   import vkd_pkg::*;

   logic [CFG_WIDTH-1:0]    init_metric_cfg_ff;
   logic [METRIC_WIDTH-1:0] init_metric;
   logic [METRIC_WIDTH-1:0] path_metric_ff [NUM_STATES];
   logic [METRIC_WIDTH-1:0] path_metric_in [NUM_STATES];
   logic [METRIC_WIDTH-1:0] cur_metric     [NUM_STATES];
   logic [1:0]              tracked_state_ff;
   logic [1:0]              tracked_state_in;
   logic [1:0]              cur_state;
   logic [1:0]              low_succ;
   logic [1:0]              high_succ;
   logic [1:0]              rx_pair;
   logic [1:0]              bm [NUM_STATES];
   logic                    stream_start;
   logic                    req_accept;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_state_ff;

   assign req_accept   = req_tvalid && req_tready;
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign stream_start = req_tuser;
   assign rx_pair      = {req_tdata[0], req_tdata[1]};

   // clip the register value to the metric width
   generate
      if (METRIC_WIDTH >= CFG_WIDTH) begin : g_init_wide
         assign init_metric = METRIC_WIDTH'(init_metric_cfg_ff);
      end else begin : g_init_narrow
         assign init_metric = (|init_metric_cfg_ff[CFG_WIDTH-1:METRIC_WIDTH]) ?
                              {METRIC_WIDTH{1'b1}} : init_metric_cfg_ff[METRIC_WIDTH-1:0];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         init_metric_cfg_ff <= CFG_WIDTH'(CFG_RESET);
      end else if (csr_wr_en) begin
         init_metric_cfg_ff <= csr_wr_data;
      end
   end

   // metrics and state in effect for this pair
   always_comb begin
      for (int s = 0; s < NUM_STATES; s++) begin
         if (stream_start) begin
            cur_metric[s] = (s == 0) ? '0 : init_metric;
         end else begin
            cur_metric[s] = path_metric_ff[s];
         end
         bm[s] = branch_distance(rx_pair, 2'(s));
      end
      cur_state = stream_start ? 2'd0 : tracked_state_ff;
   end

   vkd_acs #(.METRIC_WIDTH(METRIC_WIDTH)) u_acs0 (
      .metric_a(cur_metric[0]), .branch_a(bm[0]),
      .metric_b(cur_metric[1]), .branch_b(bm[3]),
      .metric_out(path_metric_in[0])
   );
   vkd_acs #(.METRIC_WIDTH(METRIC_WIDTH)) u_acs1 (
      .metric_a(cur_metric[2]), .branch_a(bm[2]),
      .metric_b(cur_metric[3]), .branch_b(bm[1]),
      .metric_out(path_metric_in[1])
   );
   vkd_acs #(.METRIC_WIDTH(METRIC_WIDTH)) u_acs2 (
      .metric_a(cur_metric[0]), .branch_a(bm[3]),
      .metric_b(cur_metric[1]), .branch_b(bm[0]),
      .metric_out(path_metric_in[2])
   );
   vkd_acs #(.METRIC_WIDTH(METRIC_WIDTH)) u_acs3 (
      .metric_a(cur_metric[2]), .branch_a(bm[1]),
      .metric_b(cur_metric[3]), .branch_b(bm[2]),
      .metric_out(path_metric_in[3])
   );

   // follow the better successor, lower one on a tie
   assign low_succ         = {1'b0, cur_state[1]};
   assign high_succ        = {1'b1, cur_state[1]};
   assign tracked_state_in = (path_metric_in[low_succ] <= path_metric_in[high_succ]) ?
                             low_succ : high_succ;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STATES; s++) begin
            path_metric_ff[s] <= (s == 0) ? '0 : METRIC_WIDTH'(CFG_RESET);
         end
         tracked_state_ff <= 2'd0;
      end else if (req_accept) begin
         path_metric_ff   <= path_metric_in;
         tracked_state_ff <= tracked_state_in;
      end
   end

   // output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_state_ff <= tracked_state_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-3){1'b0}}, rsp_state_ff, rsp_state_ff[1]};

   // a decision is always offered the cycle after its request is taken
   assert property (@(posedge clock) disable iff (reset)
      (!reset && req_accept) |=> rsp_valid_ff)
      else $error("result not registered after accepted request");

   // from state zero only states zero and two are reachable
   assert property (@(posedge clock) disable iff (reset)
      (!reset && req_accept && stream_start) |=> (tracked_state_ff[0] == 1'b0))
      else $error("tracked state left the start successors");

   // the lower state bit carries the previous decision
   assert property (@(posedge clock) disable iff (reset)
      (!reset && req_accept && !stream_start) |=>
         (tracked_state_ff[0] == $past(tracked_state_ff[1])))
      else $error("tracked state moved to a non-successor");

   // the offered result matches the tracked state until the next request
   assert property (@(posedge clock) disable iff (reset)
      (!reset && req_accept) |=> (rsp_state_ff == tracked_state_ff))
      else $error("result and tracked state disagree");

endmodule
